[hdl/wsd_pkg.sv]
// shared types and constants for the websocket frame deframer
`timescale 1ns / 1ps
package wsd_pkg;

	localparam logic [7:0] MASK_FLAG = 8'h80;
	localparam logic [6:0] LEN_FIELD = 7'h7F;
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [2:0] KEY_BYTES = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       empty_frame;
		logic       bad_length;
	} wsd_result_t;

endpackage

[hdl/wsd_byte_if.sv]
// request channel carrying one received stream byte
`timescale 1ns / 1ps
interface wsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

[hdl/wsd_result_if.sv]
// request channel carrying one deframed result
`timescale 1ns / 1ps
interface wsd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       empty_frame;
	logic       bad_length;

	modport source (output valid, output data_byte, output last_byte,
		output empty_frame, output bad_length, input ready);
	modport sink (input valid, input data_byte, input last_byte,
		input empty_frame, input bad_length, output ready);
endinterface

[hdl/wsd_parser.sv]
// frame header state machine and payload unmasking
`timescale 1ns / 1ps
module wsd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	output logic                 emit,
	output wsd_pkg::wsd_result_t result
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXT_HI  = 3'd2,
		PH_EXT_LO  = 3'd3,
		PH_MASK    = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_HALT    = 3'd6
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        mask_present_q, mask_present_d;
	logic [15:0] frame_length_q, frame_length_d;
	logic [15:0] bytes_seen_q, bytes_seen_d;
	logic [31:0] mask_key_q, mask_key_d;

	logic [6:0]  code;
	logic [15:0] seen_inc;
	logic [7:0]  key;

	assign code     = rx_byte[6:0] & LEN_FIELD;
	assign seen_inc = bytes_seen_q + 16'd1;

	// key byte picked by payload index mod 4, first key byte on top
	always_comb begin
		unique case (bytes_seen_q[1:0])
			2'd0: key = mask_key_q[31:24];
			2'd1: key = mask_key_q[23:16];
			2'd2: key = mask_key_q[15:8];
			default: key = mask_key_q[7:0];
		endcase
	end

	// next state and result for the byte at hand
	always_comb begin
		phase_d        = phase_q;
		mask_present_d = mask_present_q;
		frame_length_d = frame_length_q;
		bytes_seen_d   = bytes_seen_q;
		mask_key_d     = mask_key_q;
		emit           = 1'b0;
		result         = '0;
		unique case (phase_q)
			PH_HDR1: begin
				mask_present_d = (rx_byte & MASK_FLAG) != 8'h00;
				mask_key_d     = '0;
				if (code == LEN_EXT64) begin
					phase_d           = PH_HALT;
					emit              = 1'b1;
					result.bad_length = 1'b1;
				end else if (code == LEN_EXT16) begin
					phase_d = PH_EXT_HI;
				end else begin
					frame_length_d = {9'd0, code};
					bytes_seen_d   = '0;
					if (rx_byte[7]) begin
						phase_d = PH_MASK;
					end else if (code == 7'd0) begin
						phase_d            = PH_HDR0;
						emit               = 1'b1;
						result.empty_frame = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_EXT_HI: begin
				frame_length_d = {rx_byte, 8'h00};
				phase_d        = PH_EXT_LO;
			end
			PH_EXT_LO: begin
				frame_length_d = {frame_length_q[15:8], rx_byte};
				bytes_seen_d   = '0;
				if (mask_present_q) begin
					phase_d = PH_MASK;
				end else if (frame_length_d == 16'd0) begin
					phase_d            = PH_HDR0;
					emit               = 1'b1;
					result.empty_frame = 1'b1;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_MASK: begin
				mask_key_d   = {mask_key_q[23:0], rx_byte};
				bytes_seen_d = seen_inc;
				if (seen_inc >= {13'd0, KEY_BYTES}) begin
					bytes_seen_d = '0;
					if (frame_length_q == 16'd0) begin
						phase_d            = PH_HDR0;
						emit               = 1'b1;
						result.empty_frame = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				bytes_seen_d     = seen_inc;
				emit             = 1'b1;
				result.data_byte = rx_byte ^ key;
				if (seen_inc >= frame_length_q) begin
					phase_d          = PH_HDR0;
					result.last_byte = 1'b1;
				end
			end
			PH_HALT: begin
				phase_d = PH_HALT;
			end
			default: begin
				phase_d = PH_HDR1;
			end
		endcase
	end

	// state registers, updated once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HDR0;
			mask_present_q <= 1'b0;
			frame_length_q <= '0;
			bytes_seen_q   <= '0;
			mask_key_q     <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			mask_present_q <= mask_present_d;
			frame_length_q <= frame_length_d;
			bytes_seen_q   <= bytes_seen_d;
			mask_key_q     <= mask_key_d;
		end
	end

endmodule

[hdl/wsd_out_reg.sv]
// result register that drives the output channel
`timescale 1ns / 1ps
module wsd_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  wsd_pkg::wsd_result_t result,
	output logic                 free,
	wsd_result_if.source         res
);
	import wsd_pkg::*;

	logic        valid_q;
	wsd_result_t data_q;

	// register can take a new result when empty or being drained
	assign free = !valid_q || res.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= result;
		end
	end

	assign res.valid       = valid_q;
	assign res.data_byte   = data_q.data_byte;
	assign res.last_byte   = data_q.last_byte;
	assign res.empty_frame = data_q.empty_frame;
	assign res.bad_length  = data_q.bad_length;

endmodule

[hdl/websocket_frame_deframer_top.sv]
// websocket frame deframer: input register, header parser, result register
// path: input register holds the byte, result register then holds its result
// throughput: one byte per cycle unless the result register is full and not draining
// reset: arst_n clears the parser to await a first header byte and empties both registers
// after a bad length the parser drops every byte until the next reset
`timescale 1ns / 1ps
module websocket_frame_deframer_top (
	input  logic          clk,
	input  logic          arst_n,
	wsd_byte_if.sink      rx,
	wsd_result_if.source  res
);
	import wsd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        emit;
	logic        out_free;
	logic        advance;
	wsd_result_t result;

	// the held byte moves on if it yields nothing or the result register has room
	assign advance  = valid_s1 && (!emit || out_free);
	assign rx.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.emit    (emit),
		.result  (result)
	);

	wsd_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && emit),
		.result (result),
		.free   (out_free),
		.res    (res)
	);

endmodule

[test/tb.sv]
// self-checking testbench for the websocket frame deframer: random framed byte stream, scoreboard
`timescale 1ns / 1ps
module tb;
	import wsd_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 9;
	localparam int HOLD_CYCLES  = 200;
	localparam int TARGET_BYTES = 1400;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum logic [2:0] {
		PH_HDR0, PH_HDR1, PH_EXT_HI, PH_EXT_LO, PH_KEY, PH_PAYLOAD, PH_HALT
	} frame_phase_t;

	// tracks the parser state and the results each accepted byte should cause
	class frame_tracker;
		frame_phase_t phase;
		logic         masked;
		logic [15:0]  frame_len;
		logic [15:0]  seen;
		logic [31:0]  key_word;
		wsd_result_t  pending[$];
		int           mismatches;
		int           data_results;
		int           empty_results;
		int           bad_results;

		function new();
			phase = PH_HDR0;
			masked = 1'b0;
			frame_len = '0;
			seen = '0;
			key_word = '0;
			mismatches = 0;
			data_results = 0;
			empty_results = 0;
			bad_results = 0;
		endfunction

		function void queue_result(logic [7:0] d, logic l, logic e, logic b);
			wsd_result_t r;
			r.data_byte = d;
			r.last_byte = l;
			r.empty_frame = e;
			r.bad_length = b;
			pending = {pending, r};
		endfunction

		// the length is settled: go for the key, the payload, or close an empty frame
		function void length_settled();
			seen = '0;
			if (masked) begin
				phase = PH_KEY;
			end else if (frame_len == 0) begin
				phase = PH_HDR0;
				queue_result(8'h00, 1'b0, 1'b1, 1'b0);
			end else begin
				phase = PH_PAYLOAD;
			end
		endfunction

		function void absorb_byte(logic [7:0] b);
			logic [6:0] code;
			logic [7:0] key_byte;
			case (phase)
				PH_HDR1: begin
					masked = b[7];
					key_word = '0;
					code = b[6:0] & LEN_FIELD;
					if (code == LEN_EXT64) begin
						phase = PH_HALT;
						queue_result(8'h00, 1'b0, 1'b0, 1'b1);
					end else if (code == LEN_EXT16) begin
						phase = PH_EXT_HI;
					end else begin
						frame_len = {9'd0, code};
						length_settled();
					end
				end
				PH_EXT_HI: begin
					frame_len = {b, 8'h00};
					phase = PH_EXT_LO;
				end
				PH_EXT_LO: begin
					frame_len[7:0] = b;
					length_settled();
				end
				PH_KEY: begin
					key_word = {key_word[23:0], b};
					seen = seen + 16'd1;
					if (seen >= KEY_BYTES) begin
						seen = '0;
						if (frame_len == 0) begin
							phase = PH_HDR0;
							queue_result(8'h00, 1'b0, 1'b1, 1'b0);
						end else begin
							phase = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					key_byte = key_word[8 * (3 - seen[1:0]) +: 8];
					seen = seen + 16'd1;
					if (seen >= frame_len) begin
						phase = PH_HDR0;
						queue_result(b ^ key_byte, 1'b1, 1'b0, 1'b0);
					end else begin
						queue_result(b ^ key_byte, 1'b0, 1'b0, 1'b0);
					end
				end
				PH_HALT: begin
				end
				default: begin
					phase = PH_HDR1;
				end
			endcase
		endfunction

		function void match_result(wsd_result_t got);
			wsd_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h/%b/%b/%b", $time,
					got.data_byte, got.last_byte, got.empty_frame, got.bad_length);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (got.data_byte !== want.data_byte) begin
				$display("%0t: data_byte expected %h got %h", $time, want.data_byte,
					got.data_byte);
				mismatches++;
			end
			if (got.last_byte !== want.last_byte) begin
				$display("%0t: last_byte expected %b got %b", $time, want.last_byte,
					got.last_byte);
				mismatches++;
			end
			if (got.empty_frame !== want.empty_frame) begin
				$display("%0t: empty_frame expected %b got %b", $time, want.empty_frame,
					got.empty_frame);
				mismatches++;
			end
			if (got.bad_length !== want.bad_length) begin
				$display("%0t: bad_length expected %b got %b", $time, want.bad_length,
					got.bad_length);
				mismatches++;
			end
			if (want.empty_frame)
				empty_results++;
			else if (want.bad_length)
				bad_results++;
			else
				data_results++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	wsd_byte_if   rx_ch ();
	wsd_result_if res_ch ();

	websocket_frame_deframer_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	frame_tracker tracker = new();

	int  bytes_sent   = 0;
	int  frames_sent  = 0;
	int  burst_left   = 0;
	bit  steady       = 1'b0;
	bit  hold_off_req = 1'b0;
	int  cycle_count  = 0;
	int  stall_style  = 0;
	int  stall_ctr    = 0;

	// clock
	always #(CLK_HALF) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				tracker.pending.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// watch both channels: predict on each accepted byte, check each accepted result
	always @(posedge clk) begin : watch
		wsd_result_t got;
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready)
				tracker.absorb_byte(rx_ch.rx_byte);
			if (res_ch.valid && res_ch.ready) begin
				got.data_byte = res_ch.data_byte;
				got.last_byte = res_ch.last_byte;
				got.empty_frame = res_ch.empty_frame;
				got.bad_length = res_ch.bad_length;
				tracker.match_result(got);
			end
		end
	end

	// result side backpressure, with a long hold-off on request
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				res_ch.ready <= 1'b1;
			end else begin
				case (stall_style)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 9) < 7);
					default: res_ch.ready <= ((stall_ctr % 7) >= 3);
				endcase
				stall_ctr++;
				if (stall_ctr % 250 == 0)
					stall_style = $urandom_range(0, 2);
			end
		end
	end

	// offer one byte and wait for its request to be taken, idling between bursts
	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
			if (steady || hold_off_req)
				gap = 0;
			if (gap > 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// one frame with random header byte, key and payload
	task automatic send_frame(input bit masked, input logic [15:0] len, input bit use_ext);
		logic [31:0] key_word;
		int i;
		push_byte(8'($urandom_range(0, 255)));
		if (use_ext || len > 16'd125) begin
			push_byte({masked, LEN_EXT16});
			push_byte(len[15:8]);
			push_byte(len[7:0]);
		end else begin
			push_byte({masked, len[6:0]});
		end
		if (masked) begin
			key_word = $urandom;
			for (i = 3; i >= 0; i--)
				push_byte(key_word[8 * i +: 8]);
		end
		for (i = 0; i < len; i++)
			push_byte(8'($urandom_range(0, 255)));
		frames_sent++;
	endtask

	initial begin
		logic [15:0] len;
		int          pick;
		int          holds_done;
		int          i;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;
		holds_done = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unmasked empty frame
		push_byte(8'h00);
		push_byte(8'h00);
		// masked empty frame, all-ones header byte
		push_byte(8'hFF);
		push_byte(MASK_FLAG);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h00);
		// extended length of zero
		push_byte(8'h81);
		push_byte({1'b0, LEN_EXT16});
		push_byte(8'h00);
		push_byte(8'h00);
		// unmasked payload passes unchanged
		push_byte(8'h82);
		push_byte(8'h03);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'hA5);
		// masked payload, extended length below 126
		push_byte(8'h01);
		push_byte({1'b1, LEN_EXT16});
		push_byte(8'h00);
		push_byte(8'h02);
		push_byte(8'hAA);
		push_byte(8'h55);
		push_byte(8'h0F);
		push_byte(8'hF0);
		push_byte(8'hFF);
		push_byte(8'h00);
		frames_sent += 5;

		// random frames, mostly short, a few long extended ones
		while (bytes_sent < TARGET_BYTES) begin
			steady = ($urandom_range(0, 3) == 0);
			if ((holds_done == 0 && bytes_sent > 300) ||
					(holds_done == 1 && bytes_sent > 900)) begin
				// stall the result side while a long frame keeps coming
				hold_off_req = 1'b1;
				holds_done++;
				send_frame(1'($urandom_range(0, 1)), 16'd120, 1'b0);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 10)
					len = 16'd0;
				else if (pick < 60)
					len = 16'($urandom_range(1, 8));
				else if (pick < 80)
					len = 16'($urandom_range(9, 40));
				else if (pick < 90)
					len = 16'($urandom_range(100, 125));
				else if (pick < 97)
					len = 16'($urandom_range(0, 200));
				else
					len = 16'($urandom_range(256, 700));
				send_frame(1'($urandom_range(0, 1)), len,
					(pick >= 90) || ($urandom_range(0, 6) == 0));
			end
		end

		// a rejected length halts the parser; later bytes must yield nothing
		steady = 1'b0;
		push_byte(8'($urandom_range(0, 255)));
		push_byte({$urandom_range(0, 1) == 1, LEN_EXT64});
		for (i = 0; i < 16; i++)
			push_byte(8'($urandom_range(0, 255)));
		frames_sent++;
		rx_ch.valid <= 1'b0;

		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d frames in %0d bytes over %0d cycles", frames_sent, bytes_sent,
			cycle_count);
		$display("checked %0d payload bytes, %0d empty frames, %0d bad lengths; %0d mismatches",
			tracker.data_results, tracker.empty_results, tracker.bad_results,
			tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/wsd_pkg.sv
hdl/wsd_byte_if.sv
hdl/wsd_result_if.sv
hdl/wsd_parser.sv
hdl/wsd_out_reg.sv
hdl/websocket_frame_deframer_top.sv
test/tb.sv
